/* hw/rtl/first_fit_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define FFBA_ASSERT_SAME(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define FFBA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Defaults, codes, sequencer states and the control word for the cell row.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ADDR_BITS_DEF    = 24;

	localparam int KIB_W      = 15;
	localparam int THR_W      = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int KIB_SHIFT  = 10;

	localparam logic [KIB_W-1:0] HEAP_KIB_RST = 15'd1024;
	localparam logic [THR_W-1:0] SPLIT_THR_RST = 16'd16;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_KIB  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THR = 1'b1;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_RESIZE = 2'd2,
		ACT_STATS  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_FIT   = 2'd1,
		STS_NO_BLOCK = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_FIT,
		S_APPLY,
		S_RELEASE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic init;
		logic scan_start;
		logic scan_step;
		logic fit_mode;
		logic split;
		logic take;
		logic rel;
	} cell_ctrl_t;

endpackage

/* hw/rtl/ffba_cell.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator table cell
// Holds one table entry and one scan token; shifts from its lower neighbour
// when a split inserts an entry below it.
// ----------------------------------------------------------------------------
module ffba_cell import ffba_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter logic HEAD = 1'b0,
	parameter logic [ADDR_BITS-1:0] RST_SIZE = '0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [ADDR_BITS-1:0] req_size,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [ADDR_BITS-1:0] init_size,
	input  logic [ADDR_BITS-1:0] split_start,
	input  logic [ADDR_BITS-1:0] split_size,
	input  logic                 prev_valid,
	input  logic [ADDR_BITS-1:0] prev_start,
	input  logic [ADDR_BITS-1:0] prev_size,
	input  logic                 prev_free,
	input  logic                 prev_token,
	input  logic                 prev_seen,
	output logic                 valid,
	output logic [ADDR_BITS-1:0] start,
	output logic [ADDR_BITS-1:0] size,
	output logic                 free,
	output logic                 token,
	output logic                 seen,
	output logic                 hit
);

	localparam logic [ADDR_BITS-1:0] HDR = ADDR_BITS'(HEADER_BYTES);

	logic                 valid_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS-1:0] size_q;
	logic                 free_q;
	logic                 token_q;
	logic                 seen_q;
	logic [ADDR_BITS-1:0] data_off;
	logic                 cond;

	always_comb begin
		data_off = start_q + HDR;
		if (ctrl.fit_mode) begin
			cond = free_q && (size_q >= req_size);
		end else begin
			cond = (data_off == addr);
		end
		hit = token_q & valid_q & cond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= HEAD;
			start_q <= '0;
			size_q  <= RST_SIZE;
			free_q  <= HEAD;
			token_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (ctrl.init) begin
			valid_q <= HEAD;
			start_q <= '0;
			size_q  <= HEAD ? init_size : '0;
			free_q  <= HEAD;
			token_q <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			if (ctrl.scan_start) begin
				token_q <= HEAD;
				seen_q  <= HEAD;
			end else if (ctrl.scan_step) begin
				token_q <= prev_token;
				seen_q  <= seen_q | prev_token;
			end
			if (ctrl.split) begin
				if (token_q) begin
					size_q <= req_size;
					free_q <= 1'b0;
				end else if (prev_token) begin
					valid_q <= 1'b1;
					start_q <= split_start;
					size_q  <= split_size;
					free_q  <= 1'b1;
				end else if (!prev_seen) begin
					valid_q <= prev_valid;
					start_q <= prev_start;
					size_q  <= prev_size;
					free_q  <= prev_free;
				end
			end
			if (ctrl.take && token_q) begin
				free_q <= 1'b0;
			end
			if (ctrl.rel && token_q) begin
				free_q <= 1'b1;
			end
		end
	end

	assign valid = valid_q;
	assign start = start_q;
	assign size  = size_q;
	assign free  = free_q;
	assign token = token_q;
	assign seen  = seen_q;

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered heap block table kept in a row of cells, with first-fit
// allocation, splitting, free and resize, and running table statistics.
//
//   channel  handshake               word
//   in       in_valid / in_stall     action, request_size, address
//   out      out_valid / out_stall   status, addresses, counts, byte totals
//   cfg      cfg_we                  cfg_index, cfg_data
//
// A scan token walks the table one cell per cycle, so a search ends no later
// than the last valid block. A heap_kib write rebuilds the table; the reset
// state is one free block. A result still stalled at the output holds the
// sequencer in its final state until that word is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [ADDR_BITS-1:0] request_size,
	input  logic [ADDR_BITS-1:0] address,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] result_address,
	output logic [ADDR_BITS-1:0] copy_source,
	output logic [ADDR_BITS-1:0] copy_length,
	output logic [CNT_BITS-1:0]  total_block_count,
	output logic [CNT_BITS-1:0]  free_block_count,
	output logic [CNT_BITS-1:0]  used_block_count,
	output logic [ADDR_BITS-1:0] free_byte_total,
	output logic [ADDR_BITS-1:0] used_byte_total,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	`include "first_fit_block_allocator_defines.svh"

	localparam logic [ADDR_BITS-1:0] HDR = ADDR_BITS'(HEADER_BYTES);
	localparam longint MASK_L = (longint'(1) << ADDR_BITS) - 1;
	localparam longint RST_TOT = longint'(HEAP_KIB_RST) << KIB_SHIFT;
	localparam longint RST_S0 = (RST_TOT > HEADER_BYTES) ? RST_TOT - HEADER_BYTES : 0;
	localparam logic [ADDR_BITS-1:0] RST_SIZE =
		ADDR_BITS'((RST_S0 > MASK_L) ? MASK_L : RST_S0);
	localparam int IW = ((KIB_W + KIB_SHIFT > ADDR_BITS) ? KIB_W + KIB_SHIFT : ADDR_BITS) + 1;
	localparam int CW = ADDR_BITS + THR_W;

	state_t state_q, state_d;
	cell_ctrl_t ctrl;

	logic [MAX_BLOCKS-1:0] valid_v, free_v, tok_v, seen_v, hit_v, last_v;
	logic [ADDR_BITS-1:0]  start_a [MAX_BLOCKS];
	logic [ADDR_BITS-1:0]  size_a [MAX_BLOCKS];

	action_t              act_q;
	logic [ADDR_BITS-1:0] req_q, addr_q;
	logic                 refind_q;
	logic [ADDR_BITS-1:0] sel_start, sel_size, sel_start_q, sel_size_q, old_size_q;
	logic                 sel_free, sel_free_q;
	logic                 any_hit, scan_end;
	logic [THR_W-1:0]     thr_q;
	logic [CNT_BITS-1:0]  blk_cnt_q, free_cnt_q;
	logic [ADDR_BITS-1:0] free_sum_q, used_sum_q;
	status_t              sts_q;
	logic [ADDR_BITS-1:0] res_q, csrc_q, clen_q;
	logic                 out_valid_q;
	logic [1:0]           out_sts_q;
	logic [ADDR_BITS-1:0] out_res_q, out_csrc_q, out_clen_q, out_fsum_q, out_usum_q;
	logic [CNT_BITS-1:0]  out_tot_q, out_free_q, out_used_q;

	logic [IW-1:0]        tot_w, s_w;
	logic [ADDR_BITS-1:0] init_size;
	logic                 heap_wr, in_acc, do_split;
	logic [CW-1:0]        need_min, need_thr;
	logic [ADDR_BITS-1:0] split_start, split_size;

	always_comb begin
		tot_w = IW'(cfg_data[KIB_W-1:0]) << KIB_SHIFT;
		s_w   = (tot_w > IW'(HEADER_BYTES)) ? tot_w - IW'(HEADER_BYTES) : '0;
		if (s_w > IW'(MASK_L)) begin
			init_size = '1;
		end else begin
			init_size = s_w[ADDR_BITS-1:0];
		end
	end

	assign heap_wr = cfg_we && (cfg_index == REG_HEAP_KIB);

	for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
		logic                 pv, pf, pt, ps;
		logic [ADDR_BITS-1:0] pst, psz;
		if (j == 0) begin : g_head
			assign pv  = 1'b0;
			assign pf  = 1'b0;
			assign pt  = 1'b0;
			assign ps  = 1'b1;
			assign pst = '0;
			assign psz = '0;
		end else begin : g_body
			assign pv  = valid_v[j-1];
			assign pf  = free_v[j-1];
			assign pt  = tok_v[j-1];
			assign ps  = seen_v[j-1];
			assign pst = start_a[j-1];
			assign psz = size_a[j-1];
		end
		ffba_cell #(
			.ADDR_BITS(ADDR_BITS),
			.HEADER_BYTES(HEADER_BYTES),
			.HEAD(1'(j == 0)),
			.RST_SIZE((j == 0) ? RST_SIZE : '0)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.req_size(req_q),
			.addr(addr_q),
			.init_size(init_size),
			.split_start(split_start),
			.split_size(split_size),
			.prev_valid(pv),
			.prev_start(pst),
			.prev_size(psz),
			.prev_free(pf),
			.prev_token(pt),
			.prev_seen(ps),
			.valid(valid_v[j]),
			.start(start_a[j]),
			.size(size_a[j]),
			.free(free_v[j]),
			.token(tok_v[j]),
			.seen(seen_v[j]),
			.hit(hit_v[j])
		);
	end

	always_comb begin
		sel_start = '0;
		sel_size  = '0;
		sel_free  = 1'b0;
		for (int j = 0; j < MAX_BLOCKS; j++) begin
			sel_start = sel_start | (start_a[j] & {ADDR_BITS{hit_v[j]}});
			sel_size  = sel_size | (size_a[j] & {ADDR_BITS{hit_v[j]}});
			sel_free  = sel_free | (free_v[j] & hit_v[j]);
		end
		last_v   = valid_v & ~(valid_v >> 1);
		any_hit  = |hit_v;
		scan_end = |(tok_v & last_v);
	end

	always_comb begin
		need_min    = CW'(req_q) + CW'(HEADER_BYTES);
		need_thr    = need_min + CW'(thr_q);
		do_split    = ((blk_cnt_q == CNT_BITS'(1)) && (CW'(sel_size_q) >= need_min)) ||
			((CW'(sel_size_q) >= need_thr) && (blk_cnt_q < CNT_BITS'(MAX_BLOCKS)));
		split_start = sel_start_q + HDR + req_q;
		split_size  = sel_size_q - req_q - HDR;
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		ctrl.init     = heap_wr;
		ctrl.fit_mode = (state_q == S_FIT);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_ALLOC: begin
							ctrl.scan_start = 1'b1;
							state_d = S_FIT;
						end
						ACT_FREE, ACT_RESIZE: begin
							ctrl.scan_start = 1'b1;
							state_d = S_FIND;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_FIND: begin
				if (any_hit) begin
					if (act_q == ACT_FREE || refind_q) begin
						state_d = S_RELEASE;
					end else if (req_q <= sel_size) begin
						state_d = S_DONE;
					end else begin
						ctrl.scan_start = 1'b1;
						state_d = S_FIT;
					end
				end else if (scan_end) begin
					state_d = S_DONE;
				end else begin
					ctrl.scan_step = 1'b1;
				end
			end
			S_FIT: begin
				if (any_hit) begin
					state_d = S_APPLY;
				end else if (scan_end) begin
					state_d = S_DONE;
				end else begin
					ctrl.scan_step = 1'b1;
				end
			end
			S_APPLY: begin
				ctrl.split = do_split;
				ctrl.take  = !do_split;
				if (act_q == ACT_RESIZE) begin
					ctrl.scan_start = 1'b1;
					state_d = S_FIND;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RELEASE: begin
				ctrl.rel = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			thr_q      <= SPLIT_THR_RST;
			blk_cnt_q  <= CNT_BITS'(1);
			free_cnt_q <= CNT_BITS'(1);
			free_sum_q <= RST_SIZE;
			used_sum_q <= '0;
			refind_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_SPLIT_THR) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (heap_wr) begin
				blk_cnt_q  <= CNT_BITS'(1);
				free_cnt_q <= CNT_BITS'(1);
				free_sum_q <= init_size;
				used_sum_q <= '0;
			end else if (state_q == S_APPLY) begin
				if (do_split) begin
					blk_cnt_q  <= blk_cnt_q + CNT_BITS'(1);
					free_sum_q <= free_sum_q - req_q - HDR;
					used_sum_q <= used_sum_q + req_q;
				end else begin
					free_cnt_q <= free_cnt_q - CNT_BITS'(1);
					free_sum_q <= free_sum_q - sel_size_q;
					used_sum_q <= used_sum_q + sel_size_q;
				end
			end else if (state_q == S_RELEASE && !sel_free_q) begin
				free_cnt_q <= free_cnt_q + CNT_BITS'(1);
				free_sum_q <= free_sum_q + sel_size_q;
				used_sum_q <= used_sum_q - sel_size_q;
			end
			if (in_acc) begin
				refind_q <= 1'b0;
			end else if (state_q == S_APPLY && act_q == ACT_RESIZE) begin
				refind_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= action_t'(action);
			req_q  <= request_size;
			addr_q <= address;
			sts_q  <= STS_OK;
			res_q  <= '0;
			csrc_q <= '0;
			clen_q <= '0;
		end
		case (state_q)
			S_FIND: begin
				if (any_hit) begin
					sel_start_q <= sel_start;
					sel_size_q  <= sel_size;
					sel_free_q  <= sel_free;
					if (act_q == ACT_RESIZE && !refind_q) begin
						if (req_q <= sel_size) begin
							res_q <= addr_q;
						end else begin
							old_size_q <= sel_size;
						end
					end
				end else if (scan_end && !refind_q) begin
					sts_q <= STS_NO_BLOCK;
				end
			end
			S_FIT: begin
				if (any_hit) begin
					sel_start_q <= sel_start;
					sel_size_q  <= sel_size;
					sel_free_q  <= sel_free;
				end else if (scan_end) begin
					sts_q <= STS_NO_FIT;
				end
			end
			S_APPLY: begin
				res_q <= sel_start_q + HDR;
			end
			S_RELEASE: begin
				if (refind_q) begin
					csrc_q <= addr_q;
					clen_q <= old_size_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_sts_q  <= sts_q;
			out_res_q  <= res_q;
			out_csrc_q <= csrc_q;
			out_clen_q <= clen_q;
			out_tot_q  <= blk_cnt_q;
			out_free_q <= free_cnt_q;
			out_used_q <= blk_cnt_q - free_cnt_q;
			out_fsum_q <= free_sum_q;
			out_usum_q <= used_sum_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_sts_q;
	assign result_address    = out_res_q;
	assign copy_source       = out_csrc_q;
	assign copy_length       = out_clen_q;
	assign total_block_count = out_tot_q;
	assign free_block_count  = out_free_q;
	assign used_block_count  = out_used_q;
	assign free_byte_total   = out_fsum_q;
	assign used_byte_total   = out_usum_q;

	`FFBA_ASSERT_SAME(a_token_single, 1'b1, $onehot0(tok_v), "more than one scan token")
	`FFBA_ASSERT_SAME(a_hit_single, 1'b1, $onehot0(hit_v), "more than one cell hit")
	`FFBA_ASSERT_SAME(a_free_le_total, 1'b1, free_cnt_q <= blk_cnt_q,
		"free block count exceeds block count")
	`FFBA_ASSERT_SAME(a_split_room, state_q == S_APPLY && do_split,
		blk_cnt_q < CNT_BITS'(MAX_BLOCKS), "split with a full table")
	`FFBA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != S_IDLE,
		"word accepted but sequencer idle")

endmodule
